// ===== hw/rtl/nfpa_pkg.sv =====
package nfpa_pkg;

  localparam int NUM_PAGES_DEF = 256;
  localparam int PAGE_BITS_DEF = 12;

  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 32;
  localparam int STATUS_W = 3;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 32'hF600_0000;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_ALLOCATED = 3'd0;
  localparam status_t ST_NO_SPACE  = 3'd1;
  localparam status_t ST_ZERO_SIZE = 3'd2;
  localparam status_t ST_FREED     = 3'd3;
  localparam status_t ST_IGNORED   = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    scan_init;
    logic    scan_step;
    logic    mark_step;
    logic    free_init;
    logic    free_step;
    logic    clr_step;
    logic    load_out;
    status_t res;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_alloc;
    logic size_zero;
    logic size_big;
    logic free_out;
    logic scan_hit;
    logic scan_miss;
    logic mark_last;
    logic run_zero;
    logic free_last;
    logic clr_last;
  } sts_t;

endpackage

// ===== hw/rtl/nfpa_if.sv =====
interface nfpa_in_if import nfpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [SIZE_W-1:0] size_bytes;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, opcode, size_bytes, free_address, input ready);
  modport sink   (input valid, opcode, size_bytes, free_address, output ready);
endinterface

interface nfpa_out_if import nfpa_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [ADDR_W-1:0] address;

  modport source (output valid, status, address, input ready);
  modport sink   (input valid, status, address, output ready);
endinterface

interface nfpa_cfg_if import nfpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] heap_base;

  modport source (output valid, heap_base, input ready);
  modport sink   (input valid, heap_base, output ready);
endinterface

// ===== hw/rtl/nfpa_ram.sv =====
module nfpa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/nfpa_dpath.sv =====
module nfpa_dpath import nfpa_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              in_opcode,
  input  logic [SIZE_W-1:0] in_size_bytes,
  input  logic [ADDR_W-1:0] in_free_address,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_heap_base,
  output status_t           out_status,
  output logic [ADDR_W-1:0] out_address
);

  localparam int PW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CW  = $clog2(NUM_PAGES + 1);
  localparam int PGW = SIZE_W + 1 - PAGE_BITS;
  localparam logic [PW-1:0]     LAST_PAGE = PW'(NUM_PAGES - 1);
  localparam logic [PGW-1:0]    NUM_PGW   = PGW'(NUM_PAGES);
  localparam logic [ADDR_W-1:0] NUM_AW    = ADDR_W'(NUM_PAGES);

  logic [ADDR_W-1:0] heap_base_r;
  logic              opcode_r;
  logic              size_zero_r;
  logic              size_big_r;
  logic              free_out_r;
  logic [CW-1:0]     req_r;
  logic [PW-1:0]     free_idx_r;
  logic [PW-1:0]     nf_r;
  logic [PW-1:0]     eval_r;
  logic [PW-1:0]     start_r;
  logic [CW-1:0]     found_r;
  logic [PW-1:0]     first_r;
  logic [PW-1:0]     walk_r;
  logic [CW-1:0]     cnt_r;
  logic [PW-1:0]     clr_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_address_r;

  logic [PGW-1:0]    pages_w;
  logic [ADDR_W-1:0] diff_w;
  logic [ADDR_W-1:0] page_w;
  logic              used_q;
  logic [CW-1:0]     run_q;
  logic [PW-1:0]     eval_inc;
  logic [CW-1:0]     found_inc;
  logic [PW-1:0]     first_n;
  logic [PW-1:0]     walk_inc;
  logic              hit;

  logic              used_we;
  logic [PW-1:0]     used_waddr;
  logic [PW-1:0]     used_raddr;
  logic              run_we;
  logic [PW-1:0]     run_waddr;
  logic [CW-1:0]     run_wdata;

  // request decode
  assign pages_w = PGW'(in_size_bytes >> PAGE_BITS) + PGW'(|in_size_bytes[PAGE_BITS-1:0]);
  assign diff_w  = in_free_address - heap_base_r;
  assign page_w  = diff_w >> PAGE_BITS;

  // scan step on the page read last cycle
  assign eval_inc  = (eval_r == LAST_PAGE) ? '0 : eval_r + PW'(1);
  assign found_inc = found_r + CW'(1);
  assign first_n   = (!used_q && found_r == '0) ? eval_r : first_r;
  assign hit       = !used_q && (found_inc == req_r);
  assign walk_inc  = (walk_r == LAST_PAGE) ? '0 : walk_r + PW'(1);

  assign used_raddr = cmd.scan_init ? nf_r : eval_inc;

  always_comb begin
    used_we    = cmd.clr_step | cmd.mark_step | cmd.free_step;
    used_waddr = cmd.clr_step ? clr_r : walk_r;
    run_we     = cmd.clr_step | cmd.free_step | (cmd.mark_step && walk_r == first_r);
    run_waddr  = free_idx_r;
    run_wdata  = '0;
    if (cmd.clr_step) begin
      run_waddr = clr_r;
    end else if (cmd.mark_step) begin
      run_waddr = first_r;
      run_wdata = req_r;
    end
  end

  nfpa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_used_ram (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (cmd.mark_step),
    .raddr (used_raddr),
    .rdata (used_q)
  );

  nfpa_ram #(.WIDTH(CW), .DEPTH(NUM_PAGES)) u_run_ram (
    .clk   (clk),
    .we    (run_we),
    .waddr (run_waddr),
    .wdata (run_wdata),
    .raddr (free_idx_r),
    .rdata (run_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= HEAP_BASE_RST;
      nf_r        <= '0;
      clr_r       <= '0;
    end else begin
      if (cfg_we) begin
        heap_base_r <= cfg_heap_base;
      end
      if (cmd.clr_step) begin
        clr_r <= (clr_r == LAST_PAGE) ? '0 : clr_r + PW'(1);
      end
      if (cmd.mark_step) begin
        nf_r <= walk_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      opcode_r    <= in_opcode;
      size_zero_r <= (in_size_bytes == '0);
      size_big_r  <= (pages_w > NUM_PGW);
      req_r       <= pages_w[CW-1:0];
      free_out_r  <= (in_free_address < heap_base_r) || (page_w >= NUM_AW);
      free_idx_r  <= page_w[PW-1:0];
    end
    if (cmd.scan_init) begin
      eval_r  <= nf_r;
      start_r <= nf_r;
      found_r <= '0;
    end else if (cmd.scan_step) begin
      eval_r  <= eval_inc;
      found_r <= (used_q || eval_r == LAST_PAGE) ? '0 : found_inc;
      first_r <= first_n;
      walk_r  <= first_n;
      cnt_r   <= req_r;
    end
    if (cmd.free_init) begin
      walk_r <= free_idx_r;
      cnt_r  <= run_q;
    end else if (cmd.mark_step || cmd.free_step) begin
      walk_r <= walk_inc;
      cnt_r  <= cnt_r - CW'(1);
    end
    if (cmd.load_out) begin
      out_status_r  <= cmd.res;
      out_address_r <= (cmd.res == ST_ALLOCATED) ?
                       heap_base_r + (ADDR_W'(first_r) << PAGE_BITS) : '0;
    end
  end

  always_comb begin
    sts.is_alloc  = (opcode_r == OP_ALLOC);
    sts.size_zero = size_zero_r;
    sts.size_big  = size_big_r;
    sts.free_out  = free_out_r;
    sts.scan_hit  = hit;
    sts.scan_miss = !hit && (eval_inc == start_r);
    sts.mark_last = (cnt_r == CW'(1));
    sts.run_zero  = (run_q == '0);
    sts.free_last = (cnt_r == CW'(1)) || (walk_r == LAST_PAGE);
    sts.clr_last  = (clr_r == LAST_PAGE);
  end

  assign out_status  = out_status_r;
  assign out_address = out_address_r;

endmodule

// ===== hw/rtl/nfpa_ctrl.sv =====
module nfpa_ctrl import nfpa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [3:0] S_CLEAR      = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_DECODE     = 4'd2;
  localparam logic [3:0] S_SCAN_START = 4'd3;
  localparam logic [3:0] S_SCAN       = 4'd4;
  localparam logic [3:0] S_MARK       = 4'd5;
  localparam logic [3:0] S_FREE_CHK   = 4'd6;
  localparam logic [3:0] S_RELEASE    = 4'd7;
  localparam logic [3:0] S_DONE       = 4'd8;

  logic [3:0] state_r, state_nxt;
  status_t    res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    cmd           = '0;
    cmd.res       = res_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_alloc) begin
          if (sts.size_zero) begin
            res_nxt   = ST_ZERO_SIZE;
            state_nxt = S_DONE;
          end else if (sts.size_big) begin
            res_nxt   = ST_NO_SPACE;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN_START;
          end
        end else if (sts.free_out) begin
          res_nxt   = ST_IGNORED;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FREE_CHK;
        end
      end
      S_SCAN_START: begin
        cmd.scan_init = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit) begin
          state_nxt = S_MARK;
        end else if (sts.scan_miss) begin
          res_nxt   = ST_NO_SPACE;
          state_nxt = S_DONE;
        end
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_last) begin
          res_nxt   = ST_ALLOCATED;
          state_nxt = S_DONE;
        end
      end
      S_FREE_CHK: begin
        if (sts.run_zero) begin
          res_nxt   = ST_IGNORED;
          state_nxt = S_DONE;
        end else begin
          cmd.free_init = 1'b1;
          state_nxt     = S_RELEASE;
        end
      end
      S_RELEASE: begin
        cmd.free_step = 1'b1;
        if (sts.free_last) begin
          res_nxt   = ST_FREED;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register can take the word
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      res_r       <= ST_IGNORED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending word");

  a_hit_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && sts.scan_hit) |=> (state_r == S_MARK))
    else $error("scan hit did not start marking");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_step, cmd.mark_step, cmd.free_step, cmd.scan_step}))
    else $error("conflicting datapath steps");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE && !in_ready))
    else $error("accepted word not decoded");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!cmd.capture && !out_valid_r))
    else $error("activity during clearing pass");

endmodule

// ===== hw/rtl/next_fit_page_allocator.sv =====
// Next-fit page allocator.
// in_ carries one request word: opcode (allocate or free), size_bytes and
// free_address. out_ returns one word per request: status and address.
// cfg_ writes heap_base; the user must write only while the block is idle,
// which the block itself does not enforce. cfg_.ready is always high and the
// page state is kept across a base change. After reset the block sweeps both
// page tables with in_.ready low; the base returns to its reset value.
// Allocate: accept, decode and scan start, then one page of the used map per
// cycle from the next-fit pointer (up to NUM_PAGES pages), then one page
// marked per cycle, then a load of the result into the output register.
// Free: accept, decode, a check of the run length, then one page released
// per cycle. Zero-size, oversize and out-of-range requests finish right
// after decode, a free of a page with no run after the run check. in_.ready
// returns in the cycle after the result is loaded.
// The used-bit RAM read port, one page a cycle, sets the scan rate.
// One request is in work at a time. The result sits in an output register,
// so the next request is taken while out_ waits; if out_ stays stalled the
// block holds the following result and stops taking requests.
module next_fit_page_allocator import nfpa_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  nfpa_in_if.sink           in_,
  nfpa_out_if.source        out_,
  nfpa_cfg_if.sink          cfg_
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_.ready = 1'b1;

  nfpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_.valid),
    .in_ready  (in_.ready),
    .out_valid (out_.valid),
    .out_ready (out_.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  nfpa_dpath #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_.opcode),
    .in_size_bytes   (in_.size_bytes),
    .in_free_address (in_.free_address),
    .cfg_we          (cfg_.valid),
    .cfg_heap_base   (cfg_.heap_base),
    .out_status      (out_.status),
    .out_address     (out_.address)
  );

endmodule
